// ===== hw/rtl/bounded_deque_search_assert.svh =====
// Assertion macros used by the deque search checker.
`ifndef BOUNDED_DEQUE_SEARCH_ASSERT_SVH
`define BOUNDED_DEQUE_SEARCH_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define BDS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque search check failed");

// Check that a condition implies a consequence in the next cycle.
`define BDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque search check failed");

`endif

// ===== hw/rtl/bds_pkg.sv =====
// Types and constants shared by the deque search modules.
package bds_pkg;

   localparam int VALUE_W     = 32;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 3;
   localparam int POSITION_W  = 7;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
   localparam logic [OP_W-1:0] OP_PUSH_REAR  = 2'd1;

   typedef enum logic [1:0] {
      CMD_PUSH_FRONT,
      CMD_PUSH_REAR,
      CMD_SEARCH
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type               kind;
      logic signed [VALUE_W-1:0]  value;
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_INSERTED  = 3'd0,
      STATUS_FOUND     = 3'd1,
      STATUS_NOT_FOUND = 3'd2,
      STATUS_EMPTY     = 3'd3,
      STATUS_FULL      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      BS_IDLE = 2'b01,
      BS_SCAN = 2'b10
   } back_state_type;

endpackage

// ===== hw/rtl/bds_front.sv =====
// Front stage: accept request transfers and classify them into commands.
module bds_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [bds_pkg::VALUE_W-1:0]   req_tdata,  // value
   input  logic [bds_pkg::OP_W-1:0]      req_tuser,  // operation
   output logic                          cmd_valid,
   output bds_pkg::cmd_type              cmd,
   input  logic                          cmd_ready
);

   logic              hold_valid_ff;
   logic              hold_valid_in;
   bds_pkg::cmd_type  hold_cmd_ff;
   bds_pkg::cmd_type  hold_cmd_in;

   assign req_tready = !hold_valid_ff || cmd_ready;
   assign cmd_valid  = hold_valid_ff;
   assign cmd        = hold_cmd_ff;

   always_comb begin
      hold_valid_in     = req_tready ? req_tvalid : hold_valid_ff;
      hold_cmd_in.value = req_tdata;
      case (req_tuser)
         bds_pkg::OP_PUSH_FRONT: begin
            hold_cmd_in.kind = bds_pkg::CMD_PUSH_FRONT;
         end
         bds_pkg::OP_PUSH_REAR: begin
            hold_cmd_in.kind = bds_pkg::CMD_PUSH_REAR;
         end
         default: begin
            hold_cmd_in.kind = bds_pkg::CMD_SEARCH;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         hold_cmd_ff <= hold_cmd_in;
      end
   end

endmodule

// ===== hw/rtl/bds_queue.sv =====
// Short command queue between the front and back stages.
module bds_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  bds_pkg::cmd_type  push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output bds_pkg::cmd_type  pop_cmd
);

   localparam int PTR_W  = $clog2(bds_pkg::QUEUE_DEPTH);
   localparam int FILL_W = $clog2(bds_pkg::QUEUE_DEPTH + 1);

   bds_pkg::cmd_type    slot_ff [bds_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_in;
   logic [FILL_W-1:0]   fill_ff;
   logic [FILL_W-1:0]   fill_in;
   logic                push_go;
   logic                pop_go;

   assign push_ready = fill_ff != FILL_W'(bds_pkg::QUEUE_DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push_go    = push_valid && push_ready;
   assign pop_go     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_go) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(bds_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_go) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(bds_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_go && !pop_go) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop_go && !push_go) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_go) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/bds_back.sv =====
// Back stage: circular entry store, insert logic, search sequencer and result register.
module bds_back #(
   parameter int DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   output logic                              cmd_ready,
   input  bds_pkg::cmd_type                  cmd,
   output logic                              res_valid,
   input  logic                              res_ready,
   output bds_pkg::status_type               res_status,
   output logic [bds_pkg::POSITION_W-1:0]    res_position
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > bds_pkg::POSITION_W) ? CW : bds_pkg::POSITION_W;

   logic signed [bds_pkg::VALUE_W-1:0]  entry_mem_ff [DEPTH];
   logic signed [bds_pkg::VALUE_W-1:0]  rd_data_ff;

   bds_pkg::back_state_type             state_ff;
   bds_pkg::back_state_type             state_in;
   logic [IW-1:0]                       head_ff;
   logic [IW-1:0]                       head_in;
   logic [CW-1:0]                       count_ff;
   logic [CW-1:0]                       count_in;
   logic [IW-1:0]                       k_ff;
   logic [IW-1:0]                       k_in;
   logic signed [bds_pkg::VALUE_W-1:0]  key_ff;
   logic signed [bds_pkg::VALUE_W-1:0]  key_in;
   logic                                res_valid_ff;
   logic                                res_valid_in;
   bds_pkg::status_type                 res_status_ff;
   bds_pkg::status_type                 res_status_in;
   logic [bds_pkg::POSITION_W-1:0]      res_pos_ff;
   logic [bds_pkg::POSITION_W-1:0]      res_pos_in;

   logic                                wr_en;
   logic [IW-1:0]                       wr_addr;
   logic [IW-1:0]                       rd_addr;
   logic [IW-1:0]                       front_addr;
   logic [IW-1:0]                       rear_addr;
   logic [IW-1:0]                       scan_addr;
   logic [IW:0]                         rear_sum;
   logic [IW:0]                         scan_sum;
   logic [IW-1:0]                       k_next;
   logic [PW-1:0]                       pos_wide;
   logic                                full;
   logic                                last;

   assign res_valid    = res_valid_ff;
   assign res_status   = res_status_ff;
   assign res_position = res_pos_ff;

   assign full       = count_ff == CW'(DEPTH);
   assign last       = (CW'(k_ff) + CW'(1)) == count_ff;
   assign k_next     = k_ff + IW'(1);
   assign pos_wide   = PW'(k_ff) + PW'(1);
   assign front_addr = (head_ff == '0) ? IW'(DEPTH - 1) : head_ff - IW'(1);
   assign rear_sum   = {1'b0, head_ff} + {1'b0, count_ff[IW-1:0]};
   assign rear_addr  = (rear_sum >= (IW+1)'(DEPTH)) ? IW'(rear_sum - (IW+1)'(DEPTH))
                                                    : rear_sum[IW-1:0];
   assign scan_sum   = {1'b0, head_ff} + {1'b0, k_next};
   assign scan_addr  = (scan_sum >= (IW+1)'(DEPTH)) ? IW'(scan_sum - (IW+1)'(DEPTH))
                                                    : scan_sum[IW-1:0];

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      k_in          = k_ff;
      key_in        = key_ff;
      res_valid_in  = res_valid_ff && !res_ready;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      wr_en         = 1'b0;
      wr_addr       = rear_addr;
      rd_addr       = head_ff;
      cmd_ready     = 1'b0;
      case (state_ff)
         bds_pkg::BS_IDLE: begin
            cmd_ready = !res_valid_ff || res_ready;
            if (cmd_valid && cmd_ready) begin
               res_valid_in = 1'b1;
               res_pos_in   = '0;
               case (cmd.kind)
                  bds_pkg::CMD_PUSH_FRONT,
                  bds_pkg::CMD_PUSH_REAR: begin
                     if (full) begin
                        res_status_in = bds_pkg::STATUS_FULL;
                     end else begin
                        res_status_in = bds_pkg::STATUS_INSERTED;
                        wr_en         = 1'b1;
                        count_in      = count_ff + CW'(1);
                        if (cmd.kind == bds_pkg::CMD_PUSH_FRONT) begin
                           wr_addr = front_addr;
                           head_in = front_addr;
                        end
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        res_status_in = bds_pkg::STATUS_EMPTY;
                     end else begin
                        res_valid_in = 1'b0;
                        key_in       = cmd.value;
                        k_in         = '0;
                        state_in     = bds_pkg::BS_SCAN;
                     end
                  end
               endcase
            end
         end
         bds_pkg::BS_SCAN: begin
            if (rd_data_ff == key_ff) begin
               res_valid_in  = 1'b1;
               res_status_in = bds_pkg::STATUS_FOUND;
               res_pos_in    = pos_wide[bds_pkg::POSITION_W-1:0];
               state_in      = bds_pkg::BS_IDLE;
            end else if (last) begin
               res_valid_in  = 1'b1;
               res_status_in = bds_pkg::STATUS_NOT_FOUND;
               res_pos_in    = '0;
               state_in      = bds_pkg::BS_IDLE;
            end else begin
               k_in    = k_next;
               rd_addr = scan_addr;
            end
         end
         default: begin
            state_in = bds_pkg::BS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bds_pkg::BS_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= cmd.value;
      end
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

endmodule

// ===== hw/rtl/bounded_deque_search.sv =====
// Bounded deque of signed words with front-to-rear linear search.
// An insert or a search of an empty store passes the front hold register, the command queue
// and the result register. A search stops at the first match from the front or at the rear entry.
// Throughput: one insert per cycle while no search holds the back stage and the response is taken;
// a search compares one stored entry per cycle through the single read port of the store.
// Reset clears head, count and all valid flags; store contents stay undefined, no clearing pass.
module bounded_deque_search #(
   parameter int DEPTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,  // value[31:0]
   input  logic [1:0]   req_tuser,  // operation[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,  // position[6:0], zero[7]
   output logic [2:0]   rsp_tuser   // status[2:0]
);

   logic                               front_valid;
   logic                               front_ready;
   bds_pkg::cmd_type                   front_cmd;
   logic                               back_valid;
   logic                               back_ready;
   bds_pkg::cmd_type                   back_cmd;
   bds_pkg::status_type                res_status;
   logic [bds_pkg::POSITION_W-1:0]     res_position;

   bds_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (front_valid),
      .cmd        (front_cmd),
      .cmd_ready  (front_ready)
   );

   bds_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_cmd    (back_cmd)
   );

   bds_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (back_valid),
      .cmd_ready    (back_ready),
      .cmd          (back_cmd),
      .res_valid    (rsp_tvalid),
      .res_ready    (rsp_tready),
      .res_status   (res_status),
      .res_position (res_position)
   );

   assign rsp_tdata = {1'b0, res_position};
   assign rsp_tuser = res_status;

endmodule

// ===== hw/rtl/bds_checker.sv =====
// Port checker for the deque search block, bound to the top level.
`include "bounded_deque_search_assert.svh"

module bds_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [7:0]   rsp_tdata,
   input  logic [2:0]   rsp_tuser
);

   logic         rsp_stall;
   logic         rsp_other;
   logic         req_idle;
   logic [10:0]  rsp_word;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_other = rsp_tvalid && rsp_tuser != bds_pkg::STATUS_FOUND;
   assign req_idle  = req_tready && !req_tvalid;
   assign rsp_word  = {rsp_tuser, rsp_tdata};

   `BDS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))
   `BDS_ASSERT_NOW(a_status_legal, clock, reset, rsp_tvalid, rsp_tuser <= bds_pkg::STATUS_FULL)
   `BDS_ASSERT_NOW(a_pos_zero, clock, reset, rsp_other, rsp_tdata == 8'd0)
   `BDS_ASSERT_NOW(a_no_early_rsp, clock, reset, $past(reset) || $past(reset, 2), !rsp_tvalid)
   `BDS_ASSERT_NEXT(a_req_idle_ready, clock, reset, req_idle, req_tready)

endmodule

bind bounded_deque_search bds_checker u_bds_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/bounded_deque_search_test.sv =====
// Self-checking stream testbench for the bounded deque search block.
module bounded_deque_search_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 64;
   localparam int RANDOM_PER_PHASE = 150;
   localparam int HOLD_CYCLES = 400;
   localparam int MAX_GAP = 20;
   localparam int CYCLE_LIMIT = 300000;
   localparam logic [bds_pkg::OP_W-1:0] OP_SEARCH = bds_pkg::CMD_SEARCH;
   localparam logic [bds_pkg::OP_W-1:0] OP_SEARCH_ALT = 2'd3;

   typedef struct packed {
      bds_pkg::status_type              status;
      logic [bds_pkg::POSITION_W-1:0]   position;
   } outcome_type;

   class deque_shadow;
      logic signed [bds_pkg::VALUE_W-1:0] entries [DEPTH];
      logic [5:0]                head;
      logic [6:0]                count;
      outcome_type               expected_outcomes [$];
      int unsigned               errors;
      int unsigned               tally [5];
      int unsigned               deepest_hit;

      function new();
         head = '0;
         count = '0;
         errors = 0;
         deepest_hit = 0;
         foreach (tally[i]) tally[i] = 0;
      endfunction

      function logic signed [bds_pkg::VALUE_W-1:0] entry_at(int unsigned offset);
         return entries[(head + offset) % DEPTH];
      endfunction

      function void note_request(logic [bds_pkg::OP_W-1:0] op,
                                 logic signed [bds_pkg::VALUE_W-1:0] value);
         outcome_type outcome;
         bit hit;
         int k;
         outcome.position = '0;
         hit = 1'b0;
         if (op[1]) begin
            if (count == 0) begin
               outcome.status = bds_pkg::STATUS_EMPTY;
            end else begin
               outcome.status = bds_pkg::STATUS_NOT_FOUND;
               for (k = 0; k < count; k++) begin
                  if (!hit && entry_at(k) == value) begin
                     hit = 1'b1;
                     outcome.status = bds_pkg::STATUS_FOUND;
                     outcome.position = bds_pkg::POSITION_W'(k + 1);
                  end
               end
            end
         end else if (count >= DEPTH) begin
            outcome.status = bds_pkg::STATUS_FULL;
         end else begin
            if (op == bds_pkg::OP_PUSH_FRONT) begin
               head = (head == 0) ? 6'(DEPTH - 1) : head - 6'd1;
               entries[head] = value;
            end else begin
               entries[(head + count) % DEPTH] = value;
            end
            count = count + 7'd1;
            outcome.status = bds_pkg::STATUS_INSERTED;
         end
         expected_outcomes.push_back(outcome);
      endfunction

      function void check_response(logic [bds_pkg::STATUS_W-1:0] status,
                                   logic [bds_pkg::POSITION_W-1:0] position);
         outcome_type want;
         if (expected_outcomes.size() == 0) begin
            $display("%0t: unexpected response, expected none, got status %0d position %0d",
                     $time, status, position);
            errors++;
            return;
         end
         want = expected_outcomes.pop_front();
         if (status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, status);
            errors++;
         end
         if (position !== want.position) begin
            $display("%0t: position mismatch, expected %0d, got %0d",
                     $time, want.position, position);
            errors++;
         end
         if (want.status <= bds_pkg::STATUS_FULL) tally[want.status]++;
         if (want.position > deepest_hit) deepest_hit = want.position;
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;
   logic [2:0]            rsp_tuser;

   deque_shadow           shadow = new();
   int                    send_idle_pct = 18;
   int                    recv_idle_pct = 50;
   logic                  rsp_hold = 1'b0;
   int unsigned           cycle_count = 0;
   int unsigned           sent = 0;

   bounded_deque_search #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         shadow.check_response(rsp_tuser, rsp_tdata[bds_pkg::POSITION_W-1:0]);
      end
   end

   function automatic logic signed [bds_pkg::VALUE_W-1:0] any_value();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // Call at a falling edge; returns at the falling edge after the transfer.
   task automatic send_request(input logic [bds_pkg::OP_W-1:0] op,
                               input logic signed [bds_pkg::VALUE_W-1:0] value);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      shadow.note_request(op, value);
      sent++;
      @(negedge clock);
   endtask

   task automatic send_random_batch(input int n);
      logic [bds_pkg::OP_W-1:0]           op;
      logic signed [bds_pkg::VALUE_W-1:0] value;
      int                                 sel;
      repeat (n) begin
         sel = $urandom_range(99);
         if ($urandom_range(99) < 35) begin
            op = $urandom_range(1) ? bds_pkg::OP_PUSH_REAR : bds_pkg::OP_PUSH_FRONT;
            if (shadow.count != 0 && sel < 20) value = shadow.entry_at($urandom_range(shadow.count - 1));
            else value = any_value();
         end else begin
            op = $urandom_range(1) ? OP_SEARCH : OP_SEARCH_ALT;
            if (shadow.count != 0 && sel < 55) value = shadow.entry_at($urandom_range(shadow.count - 1));
            else if (shadow.count != 0 && sel < 70) value = shadow.entry_at(shadow.count - 1);
            else value = any_value();
         end
         send_request(op, value);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // search an empty store, then head wrap on the first front insert
      send_request(OP_SEARCH, 32'h0000_0000);
      send_request(OP_SEARCH_ALT, 32'hffff_ffff);
      send_request(bds_pkg::OP_PUSH_FRONT, 32'h7fff_ffff);
      send_request(bds_pkg::OP_PUSH_REAR, 32'h8000_0000);
      send_request(bds_pkg::OP_PUSH_FRONT, 32'h0000_0000);
      send_request(bds_pkg::OP_PUSH_REAR, 32'hffff_ffff);
      send_request(OP_SEARCH, 32'h0000_0000);
      send_request(OP_SEARCH_ALT, 32'h7fff_ffff);
      send_request(OP_SEARCH, 32'h8000_0000);
      send_request(OP_SEARCH, 32'hffff_ffff);
      send_request(OP_SEARCH, 32'h0000_0005);
      // duplicate at the rear: first match from the front wins
      send_request(bds_pkg::OP_PUSH_REAR, 32'h0000_0000);
      send_request(OP_SEARCH_ALT, 32'h0000_0000);
      send_request(bds_pkg::OP_PUSH_FRONT, 32'h5555_5555);
      send_request(bds_pkg::OP_PUSH_REAR, 32'haaaa_aaaa);
      send_request(OP_SEARCH_ALT, 32'haaaa_aaaa);
      send_request(OP_SEARCH, 32'h5555_5555);

      send_random_batch(RANDOM_PER_PHASE);

      send_idle_pct = 50;
      recv_idle_pct <= 18;
      send_random_batch(RANDOM_PER_PHASE);

      send_idle_pct = 0;
      recv_idle_pct <= 0;
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      send_random_batch(RANDOM_PER_PHASE);
      req_tvalid <= 1'b0;

      while (shadow.expected_outcomes.size() != 0) @(posedge clock);
      repeat (DEPTH + 10) @(posedge clock);
      if (shadow.expected_outcomes.size() != 0) begin
         $display("%0t: %0d responses still outstanding, expected 0",
                  $time, shadow.expected_outcomes.size());
         shadow.errors++;
      end

      $display("Covered %0d requests across three stall patterns and a %0d-cycle output hold-off",
               sent, HOLD_CYCLES);
      $display("Outcomes: %0d inserted, %0d found (deepest %0d), %0d missed, %0d empty, %0d full",
               shadow.tally[bds_pkg::STATUS_INSERTED], shadow.tally[bds_pkg::STATUS_FOUND],
               shadow.deepest_hit, shadow.tally[bds_pkg::STATUS_NOT_FOUND],
               shadow.tally[bds_pkg::STATUS_EMPTY], shadow.tally[bds_pkg::STATUS_FULL]);
      if (shadow.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
